### design/rek_pkg.sv
// ----------------------------------------------------------------------------
// rek_pkg
// Shared types, widths and codes for the rotary encoder with push key block.
// ----------------------------------------------------------------------------
package rek_pkg;

    // width of the internal rotation counter
    localparam int COUNT_BITS = 16;
    // width of the timestamp arithmetic
    localparam int TIME_BITS  = 32;

    // register file layout
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    localparam logic [1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [1:0] REG_SHORT_MIN  = 2'd1;
    localparam logic [1:0] REG_DIRECTION  = 2'd2;

    // register reset values
    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [15:0] SHORT_MIN_RST  = 16'd10;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // combined state codes
    localparam logic [3:0] CODE_NONE  = 4'd0;
    localparam logic [3:0] CODE_SHORT = 4'd3;
    localparam logic [3:0] CODE_LONG  = 4'd6;
    localparam logic [3:0] CODE_MAX   = 4'd8;

    // last motion seen by the decoder
    typedef enum logic [1:0] {
        MOTION_NONE = 2'd0,
        MOTION_UP   = 2'd1,
        MOTION_DOWN = 2'd2
    } motion_t;

    // key classifier states
    typedef enum logic [3:0] {
        PHASE_IDLE    = 4'b0001,
        PHASE_PRESSED = 4'b0010,
        PHASE_SHORT   = 4'b0100,
        PHASE_LONG    = 4'b1000
    } phase_t;

    // input word
    typedef struct packed {
        logic        req_type;
        logic        a_level;
        logic        b_level;
        logic        key_level;
        logic [31:0] now_ms;
    } req_t;

    // result word
    typedef struct packed {
        logic [3:0]         state_code;
        logic signed [15:0] count;
    } rsp_t;

    // configuration seen by the core
    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] short_min_ms;
        logic        direction;
    } cfg_t;

endpackage

### design/rek_regs.sv
// ----------------------------------------------------------------------------
// rek_regs
// APB register file holding the press thresholds and the count direction.
// ----------------------------------------------------------------------------
module rek_regs
    import rek_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    logic [15:0] long_press_reg;
    logic [15:0] short_min_reg;
    logic        direction_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LONG_PRESS_RST;
            short_min_reg  <= SHORT_MIN_RST;
            direction_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_LONG_PRESS: long_press_reg <= pwdata[15:0];
                REG_SHORT_MIN:  short_min_reg  <= pwdata[15:0];
                REG_DIRECTION:  direction_reg  <= pwdata[0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_LONG_PRESS: prdata = {16'd0, long_press_reg};
            REG_SHORT_MIN:  prdata = {16'd0, short_min_reg};
            REG_DIRECTION:  prdata = {31'd0, direction_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.long_press_ms = long_press_reg;
    assign cfg.short_min_ms  = short_min_reg;
    assign cfg.direction     = direction_reg;

endmodule

### design/rek_core.sv
// ----------------------------------------------------------------------------
// rek_core
// Quadrature decoder, key classifier and result register; one word per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
module rek_core
    import rek_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_word,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_word
);

    logic                  armed_reg,  armed_next;
    logic                  bfall_reg,  bfall_next;
    logic [COUNT_BITS-1:0] count_reg,  count_next;
    motion_t               motion_reg, motion_next;
    phase_t                phase_reg,  phase_next;
    logic [TIME_BITS-1:0]  start_reg,  start_next;
    logic                  valid_reg,  valid_next;
    rsp_t                  rsp_reg,    rsp_next;

    logic                    accept;
    logic                    step_en;
    logic                    step_up;
    logic [TIME_BITS-1:0]    now_t;
    logic [TIME_BITS-1:0]    held;
    logic                    at_long;
    logic                    at_short;
    logic [3:0]              base_code;
    logic [COUNT_BITS+15:0]  count_ext;

    // output register frees up when taken or empty
    assign req_ready = ~valid_reg | rsp_ready;
    assign accept    = req_valid & req_ready;

    assign now_t    = req_word.now_ms[TIME_BITS-1:0];
    assign held     = now_t - start_reg;
    assign at_long  = held >= TIME_BITS'(cfg.long_press_ms);
    assign at_short = held >= TIME_BITS'(cfg.short_min_ms);

    // code base from key phase
    always_comb
    begin
        unique case (phase_reg)
            PHASE_SHORT: base_code = CODE_SHORT;
            PHASE_LONG:  base_code = CODE_LONG;
            default:     base_code = CODE_NONE;
        endcase
    end

    // state update for one accepted word
    always_comb
    begin
        armed_next  = armed_reg;
        bfall_next  = bfall_reg;
        count_next  = count_reg;
        motion_next = motion_reg;
        phase_next  = phase_reg;
        start_next  = start_reg;
        step_en     = 1'b0;
        step_up     = 1'b0;
        rsp_next    = rsp_reg;

        if (accept)
        begin
            if (req_word.req_type == REQ_READ)
            begin
                motion_next = MOTION_NONE;
            end
            else
            begin
                // quadrature: arm on A low, decide on A high
                if (!req_word.a_level && !armed_reg)
                begin
                    armed_next = 1'b1;
                    bfall_next = req_word.b_level;
                end
                else if (req_word.a_level && armed_reg)
                begin
                    armed_next = 1'b0;
                    if (bfall_reg && !req_word.b_level)
                    begin
                        step_en = 1'b1;
                        step_up = ~cfg.direction;
                    end
                    else if (!bfall_reg && req_word.b_level)
                    begin
                        step_en = 1'b1;
                        step_up = cfg.direction;
                    end
                end

                if (step_en)
                begin
                    count_next  = step_up ? count_reg + 1'b1 : count_reg - 1'b1;
                    motion_next = step_up ? MOTION_UP : MOTION_DOWN;
                end

                // key classifier
                if (!req_word.key_level)
                begin
                    unique case (phase_reg)
                        PHASE_IDLE:
                        begin
                            phase_next = PHASE_PRESSED;
                            start_next = now_t;
                        end
                        PHASE_PRESSED:
                        begin
                            if (at_long)
                                phase_next = PHASE_LONG;
                        end
                        default: ;
                    endcase
                end
                else if (phase_reg == PHASE_PRESSED)
                begin
                    if (at_long)
                        phase_next = PHASE_LONG;
                    else if (at_short)
                        phase_next = PHASE_SHORT;
                end
                else
                begin
                    phase_next = PHASE_IDLE;
                    start_next = now_t;
                end
            end

            count_ext           = {16'd0, count_next};
            rsp_next.count      = count_ext[15:0];
            rsp_next.state_code = (req_word.req_type == REQ_READ)
                                ? base_code + {2'b00, motion_reg}
                                : CODE_NONE;
        end
        else
        begin
            count_ext = {16'd0, count_reg};
        end
    end

    assign valid_next = accept | (valid_reg & ~rsp_ready);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b0;
            bfall_reg  <= 1'b0;
            count_reg  <= '0;
            motion_reg <= MOTION_NONE;
            phase_reg  <= PHASE_IDLE;
            start_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            armed_reg  <= armed_next;
            bfall_reg  <= bfall_next;
            count_reg  <= count_next;
            motion_reg <= motion_next;
            phase_reg  <= phase_next;
            start_reg  <= start_next;
            valid_reg  <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

### design/rotary_encoder_with_press_key.sv
// ----------------------------------------------------------------------------
// rotary_encoder_with_press_key
// Rotary encoder decoder with short and long press key detection.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per sample or read. req_type 0 carries the A, B and
//   key pin levels plus a millisecond timestamp; req_type 1 asks for the
//   combined key/motion code and clears the recorded motion.
//   rsp channel: exactly one word per request, holding state_code (0 for
//   samples) and the rotation count after the request.
//   The result is registered: a word taken on req shows on rsp in the cycle
//   after. Throughput is one word per cycle while rsp_ready is high; the single
//   output register is the only stage, and the next request is taken in the
//   same cycle the pending result is taken.
//   When the receiver stalls, the result holds in the output register and
//   req_ready drops until it is taken.
//   Reset clears the count, the decoder arming, the motion and the key phase,
//   and loads the thresholds with 1000 ms (long) and 10 ms (short minimum).
//   The APB port holds long_press_ms at 0x0, short_min_ms at 0x4 and
//   direction at 0x8; pready is always high. Write registers only while idle.
// ----------------------------------------------------------------------------
module rotary_encoder_with_press_key
    import rek_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req_word,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp_word
);

    cfg_t cfg;

    // configuration registers
    rek_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // decoder and result stage
    rek_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

endmodule

### design/rek_checker.sv
// ----------------------------------------------------------------------------
// rek_checker
// Port-level checks of the rotary encoder block, bound to the top level.
// ----------------------------------------------------------------------------
module rek_checker
    import rek_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req_word,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_word
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("stalled result changed");

    // every accepted word gives a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted word gave no result");

    // sample words return no code
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_word.req_type == REQ_SAMPLE
        |=> rsp_word.state_code == CODE_NONE)
        else $error("sample word returned a code");

    // read leaves the count unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && rsp_valid && rsp_ready
        && req_word.req_type == REQ_READ
        |=> rsp_word.count == $past(rsp_word.count))
        else $error("read moved the count");

    // codes stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_word.state_code <= CODE_MAX)
        else $error("state code out of range");

endmodule

bind rotary_encoder_with_press_key rek_checker u_rek_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
);

### test/tb_rotary_encoder_with_press_key.sv
// ----------------------------------------------------------------------------
// tb_rotary_encoder_with_press_key
// Self-checking bench for the rotary encoder with push key. A short table of
// hand-written words comes first, then a short down-count run from one into
// negative counts, then six randomized phases under different thresholds and
// direction settings. Quadrature steps, key presses and reads are mostly
// well-formed, with some noise. Each result word is checked against a table
// value or an in-bench model of the decoder and key classifier. Random gaps
// hit both handshakes; the register port is read back after each write.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_with_press_key;
    import rek_pkg::*;

    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          PHASE_WORDS  = 310;
    localparam int          SWEEP_STEPS  = 30;
    localparam int          PRINT_LIMIT  = 30;
    // register index past the end of the register list
    localparam logic [1:0]  REG_SPARE    = 2'd3;

    // one row of the directed table
    typedef struct {
        req_t w;
        bit   fixed;
        rsp_t want;
    } drill_row_t;

    // dut ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_BITS-1:0] paddr     = '0;
    logic [DATA_BITS-1:0] pwdata    = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req_word  = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp_word;

    // model state of the decoder and key classifier
    logic                 enc_armed   = 1'b0;
    logic                 enc_b_latch = 1'b0;
    logic signed [15:0]   rot_count   = '0;
    motion_t              last_motion = MOTION_NONE;
    phase_t               key_state   = PHASE_IDLE;
    logic [31:0]          press_t0    = '0;
    logic [15:0]          cfg_long    = LONG_PRESS_RST;
    logic [15:0]          cfg_short   = SHORT_MIN_RST;
    logic                 cfg_dir     = 1'b0;

    // random stimulus state
    int                   enc_pos     = 0;
    logic                 spin_back   = 1'b0;
    logic                 key_lvl     = 1'b1;
    logic [31:0]          clock_ms    = '0;

    rsp_t                 pending_rsp[$];
    drill_row_t           drill_q[$];
    bit                   calm        = 1'b0;
    int                   errors      = 0;
    int                   printed     = 0;
    int                   cycles      = 0;
    int                   hold_left   = 0;
    int                   words_sent  = 0;
    int                   reads_sent  = 0;
    int                   rsp_checked = 0;
    int                   settings    = 1;

    rotary_encoder_with_press_key dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        else if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // pin levels (a, b) at each quadrature position, forward order
    function automatic logic [1:0] gray_pins(int p);
        case (p & 3)
            0: return 2'b11;
            1: return 2'b01;
            2: return 2'b00;
            default: return 2'b10;
        endcase
    endfunction

    function automatic req_t sample_word(logic a, logic b, logic key, logic [31:0] t);
        req_t w;
        w.req_type  = REQ_SAMPLE;
        w.a_level   = a;
        w.b_level   = b;
        w.key_level = key;
        w.now_ms    = t;
        return w;
    endfunction

    function automatic req_t read_word();
        req_t w;
        w           = '0;
        w.req_type  = REQ_READ;
        return w;
    endfunction

    function automatic rsp_t rsp_of(logic [3:0] code, logic signed [15:0] cnt);
        rsp_t r;
        r.state_code = code;
        r.count      = cnt;
        return r;
    endfunction

    // decoder and key classifier: updates model state, returns the result word
    task automatic decode_and_classify(input req_t w, output rsp_t r);
        logic [31:0] held;
        logic        step;
        logic        up;
        step = 1'b0;
        up   = 1'b0;
        r.state_code = CODE_NONE;
        if (w.req_type == REQ_READ)
        begin
            if (key_state == PHASE_SHORT)
                r.state_code = CODE_SHORT;
            else if (key_state == PHASE_LONG)
                r.state_code = CODE_LONG;
            r.state_code = r.state_code + {2'b00, last_motion};
            last_motion  = MOTION_NONE;
        end
        else
        begin
            // quadrature: arm on a low, judge b on the next a high
            if (!w.a_level && !enc_armed)
            begin
                enc_armed   = 1'b1;
                enc_b_latch = w.b_level;
            end
            else if (w.a_level && enc_armed)
            begin
                enc_armed = 1'b0;
                if (enc_b_latch && !w.b_level)
                begin
                    step = 1'b1;
                    up   = !cfg_dir;
                end
                else if (!enc_b_latch && w.b_level)
                begin
                    step = 1'b1;
                    up   = cfg_dir;
                end
            end
            if (step)
            begin
                rot_count   = up ? rot_count + 16'sd1 : rot_count - 16'sd1;
                last_motion = up ? MOTION_UP : MOTION_DOWN;
            end
            // key phase, held time modulo 2^32
            held = w.now_ms - press_t0;
            if (!w.key_level)
            begin
                if (key_state == PHASE_IDLE)
                begin
                    key_state = PHASE_PRESSED;
                    press_t0  = w.now_ms;
                end
                else if (key_state == PHASE_PRESSED && held >= {16'd0, cfg_long})
                    key_state = PHASE_LONG;
            end
            else if (key_state == PHASE_PRESSED)
            begin
                if (held >= {16'd0, cfg_short} && held < {16'd0, cfg_long})
                    key_state = PHASE_SHORT;
                else if (held >= {16'd0, cfg_long})
                    key_state = PHASE_LONG;
            end
            else
            begin
                key_state = PHASE_IDLE;
                press_t0  = w.now_ms;
            end
        end
        r.count = rot_count;
    endtask

    // offer one word after a random gap, predict once it is taken
    task automatic send_word(input req_t w, input bit fixed, input rsp_t want);
        int   gap;
        rsp_t guess;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        decode_and_classify(w, guess);
        pending_rsp.push_back(fixed ? want : guess);
        words_sent++;
        if (w.req_type == REQ_READ)
            reads_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // apb write, also mirrored into the model
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LONG_PRESS: cfg_long  = data[15:0];
            REG_SHORT_MIN:  cfg_short = data[15:0];
            REG_DIRECTION:  cfg_dir   = data[0];
            default: ;
        endcase
    endtask

    // apb read, compared with the mirrored register
    task automatic reg_check(input logic [1:0] idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            errors++;
            $display("%0t: register %0d expected %h got %h", $time, idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new thresholds and direction, written while idle and read back
    task automatic configure(input logic [31:0] lng, input logic [31:0] sht,
                             input logic [31:0] dir);
        drain();
        reg_write(REG_LONG_PRESS, lng);
        reg_write(REG_SHORT_MIN, sht);
        reg_write(REG_DIRECTION, dir);
        reg_check(REG_LONG_PRESS, {16'd0, cfg_long});
        reg_check(REG_SHORT_MIN, {16'd0, cfg_short});
        reg_check(REG_DIRECTION, {31'd0, cfg_dir});
        settings++;
    endtask

    // random word: mostly clean quadrature and key holds, some noise and reads
    task automatic roll_word(output req_t w);
        int         r;
        int         p;
        logic [1:0] ab;
        r = $urandom_range(0, 99);
        if (r < 18)
        begin
            w.req_type  = REQ_READ;
            w.a_level   = 1'($urandom_range(0, 1));
            w.b_level   = 1'($urandom_range(0, 1));
            w.key_level = 1'($urandom_range(0, 1));
            w.now_ms    = $urandom;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                clock_ms = clock_ms + $urandom_range(0, 15);
            else if (r < 90)
                clock_ms = clock_ms + $urandom_range(0, 200);
            else if (r < 97)
                clock_ms = clock_ms + $urandom_range(0, 3000);
            else
                clock_ms = $urandom;
            p = $urandom_range(0, 99);
            if (p < 12)
                ab = 2'($urandom);
            else if (p < 30)
                ab = gray_pins(enc_pos);
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    spin_back = !spin_back;
                enc_pos = spin_back ? enc_pos + 3 : enc_pos + 1;
                ab = gray_pins(enc_pos);
            end
            if ($urandom_range(0, 11) == 0)
                key_lvl = !key_lvl;
            w = sample_word(ab[1], ab[0], key_lvl, clock_ms);
        end
    endtask

    // result check against the oldest expectation
    task automatic check_result(input rsp_t got);
        rsp_t want;
        rsp_checked++;
        if (pending_rsp.size() == 0)
        begin
            errors++;
            if (printed < PRINT_LIMIT)
                $display("%0t: unexpected word code %0d count %0d",
                         $time, got.state_code, got.count);
            printed++;
        end
        else
        begin
            want = pending_rsp.pop_front();
            if (got.state_code !== want.state_code)
            begin
                errors++;
                if (printed < PRINT_LIMIT)
                    $display("%0t: state_code expected %0d got %0d",
                             $time, want.state_code, got.state_code);
                printed++;
            end
            if (got.count !== want.count)
            begin
                errors++;
                if (printed < PRINT_LIMIT)
                    $display("%0t: count expected %0d got %0d",
                             $time, want.count, got.count);
                printed++;
            end
        end
    endtask

    // result side: check taken words, stall at random
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            check_result(rsp_word);
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                hold_left <= pick_gap();
        end
    end

    // directed table, default thresholds
    task automatic build_drill();
        drill_row_t row;
        rsp_t       none;
        none = rsp_of(CODE_NONE, 16'sd0);
        row = '{read_word(), 1'b1, rsp_of(CODE_NONE, 16'sd0)};
        drill_q.push_back(row);
        // one clean step up, then read and clear the motion
        row = '{sample_word(1'b0, 1'b1, 1'b1, 32'd0), 1'b1, rsp_of(CODE_NONE, 16'sd0)};
        drill_q.push_back(row);
        row = '{sample_word(1'b1, 1'b0, 1'b1, 32'd1), 1'b1, rsp_of(CODE_NONE, 16'sd1)};
        drill_q.push_back(row);
        row = '{read_word(), 1'b1, rsp_of(CODE_NONE + {2'b00, MOTION_UP}, 16'sd1)};
        drill_q.push_back(row);
        row = '{read_word(), 1'b1, rsp_of(CODE_NONE, 16'sd1)};
        drill_q.push_back(row);
        // one clean step down
        row = '{sample_word(1'b0, 1'b0, 1'b1, 32'd2), 1'b0, none};
        drill_q.push_back(row);
        row = '{sample_word(1'b1, 1'b1, 1'b1, 32'd3), 1'b0, none};
        drill_q.push_back(row);
        row = '{read_word(), 1'b1, rsp_of(CODE_NONE + {2'b00, MOTION_DOWN}, 16'sd0)};
        drill_q.push_back(row);
        // a high while disarmed, a low while armed, no b change
        row = '{sample_word(1'b1, 1'b1, 1'b1, 32'd4), 1'b0, none};
        drill_q.push_back(row);
        row = '{sample_word(1'b0, 1'b1, 1'b1, 32'd5), 1'b0, none};
        drill_q.push_back(row);
        row = '{sample_word(1'b0, 1'b0, 1'b1, 32'd6), 1'b0, none};
        drill_q.push_back(row);
        row = '{sample_word(1'b1, 1'b1, 1'b1, 32'd7), 1'b0, none};
        drill_q.push_back(row);
        // press, release too early, then a short press
        row = '{sample_word(1'b1, 1'b1, 1'b0, 32'd100), 1'b0, none};
        drill_q.push_back(row);
        row = '{sample_word(1'b1, 1'b1, 1'b1, 32'd105), 1'b0, none};
        drill_q.push_back(row);
        row = '{sample_word(1'b1, 1'b1, 1'b1, 32'd120), 1'b0, none};
        drill_q.push_back(row);
        row = '{read_word(), 1'b0, none};
        drill_q.push_back(row);
        // holding in short changes nothing, release goes idle
        row = '{sample_word(1'b1, 1'b1, 1'b0, 32'd200), 1'b0, none};
        drill_q.push_back(row);
        row = '{sample_word(1'b1, 1'b1, 1'b1, 32'd210), 1'b0, none};
        drill_q.push_back(row);
        // long press across the timestamp wrap, with a step up while long
        row = '{sample_word(1'b1, 1'b1, 1'b0, 32'hFFFF_FF00), 1'b0, none};
        drill_q.push_back(row);
        row = '{sample_word(1'b1, 1'b1, 1'b0, 32'h0000_0300), 1'b0, none};
        drill_q.push_back(row);
        row = '{sample_word(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF), 1'b0, none};
        drill_q.push_back(row);
        row = '{sample_word(1'b1, 1'b0, 1'b0, 32'h0000_0310), 1'b0, none};
        drill_q.push_back(row);
        row = '{read_word(), 1'b0, none};
        drill_q.push_back(row);
        // release in long goes idle
        row = '{sample_word(1'b1, 1'b0, 1'b1, 32'h8000_0000), 1'b0, none};
        drill_q.push_back(row);
        row = '{read_word(), 1'b0, none};
        drill_q.push_back(row);
    endtask

    // main sequence
    initial
    begin
        req_t w;
        rsp_t none;
        none = rsp_of(CODE_NONE, 16'sd0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        build_drill();
        foreach (drill_q[i])
            send_word(drill_q[i].w, drill_q[i].fixed, drill_q[i].want);
        drain();

        // short down-count run from one into negative counts, no idling
        calm = 1'b1;
        for (int i = 0; i < SWEEP_STEPS; i++)
        begin
            send_word(sample_word(1'b0, 1'b0, 1'b1, 32'd50), 1'b0, none);
            send_word(sample_word(1'b1, 1'b1, 1'b1, 32'd50), 1'b0, none);
        end
        send_word(read_word(), 1'b0, none);
        drain();
        calm = 1'b0;

        // random phases under different settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    // upper bits dropped: long of zero, short of three, swapped
                    configure(32'hA5A5_0000, 32'h1234_0003, 32'hFFFF_FFFF);
                    reg_write(REG_SPARE, 32'hFFFF_FFFF);
                    reg_check(REG_LONG_PRESS, {16'd0, cfg_long});
                end
                1: configure(32'd65535, 32'd65535, 32'd0);
                2: configure(32'd1, 32'd0, 32'd1);
                5: configure({16'd0, LONG_PRESS_RST}, {16'd0, SHORT_MIN_RST}, 32'd0);
                default: configure($urandom_range(20, 300), $urandom_range(0, 30),
                                   $urandom_range(0, 1));
            endcase
            calm = (ph == 2);
            if (ph == 3)
                clock_ms = 32'hFFFF_F000;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // now and then hold off until everything is back
                if ($urandom_range(0, 99) == 0)
                    drain();
                roll_word(w);
                send_word(w, 1'b0, none);
            end
        end
        calm = 1'b0;

        drain();
        repeat (4) @(posedge clk);
        $display("run: %0d words sent, %0d of them reads, %0d results checked",
                 words_sent, reads_sent, rsp_checked);
        $display("run: %0d register settings, count taken below zero and back",
                 settings);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
design/rek_pkg.sv
design/rek_regs.sv
design/rek_core.sv
design/rotary_encoder_with_press_key.sv
design/rek_checker.sv
test/tb_rotary_encoder_with_press_key.sv
